@@ hdl/srbt_pkg.sv @@
// ----------------------------------------------------------------------------
// srbt_pkg
// Shared types and constants of the shaped-rate blink timer: register
// indexes, zone modes, sequencer states and the shaper request/response.
// ----------------------------------------------------------------------------
package srbt_pkg;

  localparam int unsigned RATE_W  = 8;
  localparam int unsigned PER_W   = 16;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned PROD_W  = PER_W + RATE_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [RATE_W-1:0] RATE_MID = 8'd127;
  localparam logic [RATE_W-1:0] RATE_OFF = 8'd0;
  localparam logic [RATE_W-1:0] RATE_ON  = 8'd255;
  localparam logic [FRAC_W-1:0] ROUND_UP = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MID_PERIOD  = 3'd0,
    REG_EDGE_PERIOD = 3'd1,
    REG_CURVE_EXP   = 3'd2,
    REG_FORE_COLOR  = 3'd3,
    REG_BACK_COLOR  = 3'd4,
    REG_ZONE_MODE   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ZONE_NONE = 2'd0,
    ZONE_FORE = 2'd1,
    ZONE_BACK = 2'd2,
    ZONE_BOTH = 2'd3
  } zone_mode_t;

  typedef enum logic [4:0] {
    SH_IDLE  = 5'b00001,
    SH_SHAPE = 5'b00010,
    SH_SHEND = 5'b00100,
    SH_PER   = 5'b01000,
    SH_FIN   = 5'b10000
  } shp_state_t;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_CALC = 3'b010,
    T_EMIT = 3'b100
  } top_state_t;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] rate;
  } shp_req_t;

  typedef struct packed {
    logic             done;
    logic [PER_W-1:0] period;
  } shp_rsp_t;

endpackage

@@ hdl/shaped_rate_blink_timer.sv @@
// ----------------------------------------------------------------------------
// shaped_rate_blink_timer
// Blink timer whose period is shaped from a rate by a signed power curve.
//
// Input channel (in_valid/in_stall) carries one beat: now_ms and rate. The
// result channel (out_valid/out_stall) returns one beat per input beat:
// polarity, apply and the red/green/blue color to paint.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata);
// registers 0..5 are mid period, edge period, curve exponent, fore color,
// back color and zone mode. Write only while the block is idle.
// Rate 0 or 255 skips the shaper and goes straight to emit; exponent 0
// skips the curve; else the shared multiplier runs |curve_exponent| curve
// steps, one curve step per cycle, then one period multiply. One beat is
// worked at a time; in_stall stays high until the result is loaded into
// the output register.
// A stalled output beat holds; the next input beat is accepted meanwhile and
// its result waits until the output register frees.
// Reset clears the state, config, output valid, the toggle stamp and the phase (background).
// ----------------------------------------------------------------------------
module shaped_rate_blink_timer
  import srbt_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_now_ms,
  input  logic [RATE_W-1:0]    in_rate,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_polarity,
  output logic                 out_apply,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata
);

  top_state_t               state_r, state_nxt;
  logic [TIME_BITS-1:0]     now_r;
  logic [TIME_BITS-1:0]     stamp_r;
  logic                     phase_r;
  logic [PER_W-1:0]         mid_r, edge_r;
  logic signed [RATE_W-1:0] exp_r;
  logic [COLOR_W-1:0]       fore_r, back_r;
  zone_mode_t               zone_r;
  logic                     out_valid_r;
  logic                     out_pol_r, out_apply_r;
  logic [COLOR_W-1:0]       out_color_r;

  logic                     in_acc;
  logic                     forced;
  logic [63:0]              now_ext;
  logic [TIME_BITS-1:0]     now_w;
  logic [TIME_BITS-1:0]     elapsed;
  logic                     out_free;
  logic                     apply_w;
  logic [COLOR_W-1:0]       color_w;
  shp_req_t                 req;
  shp_rsp_t                 rsp;

  assign in_stall = (state_r != T_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign forced   = (in_rate == RATE_OFF) || (in_rate == RATE_ON);
  assign now_ext  = {32'd0, in_now_ms};
  assign now_w    = now_ext[TIME_BITS-1:0];
  assign elapsed  = now_r - stamp_r;
  assign out_free = !out_valid_r || !out_stall;

  assign req.start = in_acc && !forced;
  assign req.rate  = in_rate;

  srbt_shaper u_shaper (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .mid_period  (mid_r),
    .edge_period (edge_r),
    .curve_exp   (exp_r),
    .rsp         (rsp)
  );

  always_comb begin
    apply_w = 1'b0;
    color_w = '0;
    case (zone_r)
      ZONE_FORE: begin
        apply_w = phase_r;
        color_w = phase_r ? fore_r : '0;
      end
      ZONE_BACK: begin
        apply_w = !phase_r;
        color_w = phase_r ? '0 : back_r;
      end
      ZONE_BOTH: begin
        apply_w = 1'b1;
        color_w = phase_r ? fore_r : back_r;
      end
      default: begin
        apply_w = 1'b0;
        color_w = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: if (in_acc) state_nxt = forced ? T_EMIT : T_CALC;
      T_CALC: if (rsp.done) state_nxt = T_EMIT;
      T_EMIT: if (out_free) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  // advance the control state, stamp, phase, config and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      stamp_r     <= '0;
      phase_r     <= 1'b0;
      mid_r       <= '0;
      edge_r      <= '0;
      exp_r       <= '0;
      fore_r      <= '0;
      back_r      <= '0;
      zone_r      <= ZONE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_MID_PERIOD:  mid_r  <= cfg_wdata[PER_W-1:0];
          REG_EDGE_PERIOD: edge_r <= cfg_wdata[PER_W-1:0];
          REG_CURVE_EXP:   exp_r  <= cfg_wdata[RATE_W-1:0];
          REG_FORE_COLOR:  fore_r <= cfg_wdata;
          REG_BACK_COLOR:  back_r <= cfg_wdata;
          REG_ZONE_MODE:   zone_r <= zone_mode_t'(cfg_wdata[1:0]);
          default: ;
        endcase
      end
      if (in_acc && forced) begin
        stamp_r <= now_w;
        phase_r <= (in_rate == RATE_ON);
      end
      if (state_r == T_CALC && rsp.done && elapsed > TIME_BITS'(rsp.period)) begin
        stamp_r <= now_r;
        phase_r <= !phase_r;
      end
      if (state_r == T_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= now_w;
    end
    if (state_r == T_EMIT && out_free) begin
      out_pol_r   <= phase_r;
      out_apply_r <= apply_w;
      out_color_r <= color_w;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_polarity = out_pol_r;
  assign out_apply    = out_apply_r;
  assign out_red      = out_color_r[23:16];
  assign out_green    = out_color_r[15:8];
  assign out_blue     = out_color_r[7:0];

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input accepted while not idle next cycle");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == T_CALC))
    else $error("shaper done outside of calc");

  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == T_EMIT))
    else $error("output loaded outside of emit");

  a_forced_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_rate == RATE_ON) |=> phase_r)
    else $error("rate on did not force phase high");
`endif

endmodule

@@ hdl/srbt_mul.sv @@
// ----------------------------------------------------------------------------
// srbt_mul
// Shared 16x8 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module srbt_mul
  import srbt_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [PER_W-1:0]  a,
  input  logic [RATE_W-1:0] b,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

  assign prod = prod_r;

endmodule

@@ hdl/srbt_shaper.sv @@
// ----------------------------------------------------------------------------
// srbt_shaper
// Sequencer that folds the rate, bends it by the signed power curve one
// multiply per cycle and interpolates the blink period on the same multiplier.
// ----------------------------------------------------------------------------
module srbt_shaper
  import srbt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  shp_req_t                 req,
  input  logic [PER_W-1:0]         mid_period,
  input  logic [PER_W-1:0]         edge_period,
  input  logic signed [RATE_W-1:0] curve_exp,
  output shp_rsp_t                 rsp
);

  shp_state_t        state_r, state_nxt;
  logic [RATE_W-1:0] cnt_r, cnt_nxt;
  logic              first_r, first_nxt;
  logic              neg_r, neg_nxt;
  logic [RATE_W-1:0] base_r, base_nxt;
  logic [RATE_W-1:0] s_r, s_nxt;

  logic              mul_en;
  logic [PER_W-1:0]  mul_a;
  logic [RATE_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;

  logic [RATE_W-1:0] fold;
  logic [RATE_W-1:0] m;
  logic [RATE_W-1:0] mag;
  logic              up;
  logic [PER_W-1:0]  diff;
  logic [PROD_W:0]   sum_rnd;
  logic [PER_W-1:0]  q;
  logic [RATE_W-1:0] t;

  srbt_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign fold    = (req.rate > RATE_MID) ? ~req.rate : req.rate;
  assign m       = {fold[RATE_W-2:0], 1'b0};
  assign mag     = curve_exp[RATE_W-1] ? (~curve_exp + 8'd1) : curve_exp;
  assign up      = (edge_period >= mid_period);
  assign diff    = up ? (edge_period - mid_period) : (mid_period - edge_period);
  assign sum_rnd = {1'b0, prod} + (PROD_W + 1)'(ROUND_UP);
  assign q       = up ? prod[PROD_W-1:FRAC_W] : sum_rnd[PROD_W-1:FRAC_W];
  assign t       = prod[2*FRAC_W-1:FRAC_W];

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    neg_nxt    = neg_r;
    base_nxt   = base_r;
    s_nxt      = s_r;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    rsp.done   = 1'b0;
    rsp.period = up ? (edge_period - q) : (edge_period + q);
    unique case (state_r)
      SH_IDLE: begin
        if (req.start) begin
          neg_nxt   = curve_exp[RATE_W-1];
          base_nxt  = curve_exp[RATE_W-1] ? ~m : m;
          cnt_nxt   = mag;
          first_nxt = 1'b1;
          s_nxt     = m;
          state_nxt = (mag == '0) ? SH_PER : SH_SHAPE;
        end
      end
      SH_SHAPE: begin
        mul_en    = 1'b1;
        mul_a     = first_r ? PER_W'(base_r) : PER_W'(t);
        mul_b     = base_r;
        first_nxt = 1'b0;
        cnt_nxt   = cnt_r - 8'd1;
        if (cnt_r == 8'd1) begin
          state_nxt = SH_SHEND;
        end
      end
      SH_SHEND: begin
        s_nxt     = neg_r ? ~t : t;
        state_nxt = SH_PER;
      end
      SH_PER: begin
        mul_en    = 1'b1;
        mul_a     = diff;
        mul_b     = s_r;
        state_nxt = SH_FIN;
      end
      SH_FIN: begin
        rsp.done  = 1'b1;
        state_nxt = SH_IDLE;
      end
      default: state_nxt = SH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    first_r <= first_nxt;
    neg_r   <= neg_nxt;
    base_r  <= base_nxt;
    s_r     <= s_nxt;
  end

endmodule
